[hw/rtl/tdc_pkg.sv]
// Shared types, constants and helper functions for the 2D transform composer.
package tdc_pkg;

   // CORDIC datapath sizing
   localparam int CORDIC_ITERS     = 16;
   localparam int CORDIC_PER_STAGE = 2;
   localparam int CORDIC_STAGES    = CORDIC_ITERS / CORDIC_PER_STAGE;
   localparam int XW               = 34;   // Q2.30 x/y plus growth headroom
   localparam int ZW               = 26;   // Q10.16 degrees, residual angle
   localparam int CW               = 18;   // trig value, Q16 in [-1, 1]
   localparam int AW               = 48;   // rounded local*scale, Q.8
   localparam int TW               = 50;   // rounded axis term, Q.8

   localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [ZW-1:0] DEG360 = 26'sd23592960;
   localparam logic signed [ZW-1:0] DEG180 = 26'sd11796480;
   localparam logic signed [ZW-1:0] DEG90  = 26'sd5898240;
   localparam logic signed [CW-1:0] UNIT_Q16 = 18'sd65536;

   // Input transaction payload
   typedef struct packed {
      logic signed [31:0] local_x;
      logic signed [31:0] local_y;
      logic signed [31:0] local_angle;
      logic signed [31:0] local_scale_x;
      logic signed [31:0] local_scale_y;
      logic signed [31:0] parent_x;
      logic signed [31:0] parent_y;
      logic signed [31:0] parent_angle;
      logic signed [31:0] parent_scale_x;
      logic signed [31:0] parent_scale_y;
      logic               parent_valid;
   } req_type;

   // Result transaction payload
   typedef struct packed {
      logic signed [31:0] global_x;
      logic signed [31:0] global_y;
      logic signed [31:0] global_angle;
      logic signed [31:0] global_scale_x;
      logic signed [31:0] global_scale_y;
   } rsp_type;

   // Arctangent table in Q16.16 degrees
   function automatic logic signed [ZW-1:0] atan_deg(input int idx);
      logic signed [ZW-1:0] a;
      case (idx)
         0:       a = 26'sd2949120;
         1:       a = 26'sd1740967;
         2:       a = 26'sd919879;
         3:       a = 26'sd466945;
         4:       a = 26'sd234379;
         5:       a = 26'sd117304;
         6:       a = 26'sd58666;
         7:       a = 26'sd29335;
         8:       a = 26'sd14668;
         9:       a = 26'sd7334;
         10:      a = 26'sd3667;
         11:      a = 26'sd1833;
         12:      a = 26'sd917;
         13:      a = 26'sd458;
         14:      a = 26'sd229;
         15:      a = 26'sd115;
         default: a = '0;
      endcase
      return a;
   endfunction

   // Saturate a wide signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -66'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

[hw/rtl/tdc_req_if.sv]
// Valid/ready channel carrying one input transaction.
interface tdc_req_if;
   import tdc_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/tdc_rsp_if.sv]
// Valid/ready channel carrying one result transaction.
interface tdc_rsp_if;
   import tdc_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/tdc_cordic.sv]
// Pipelined rotation-mode CORDIC, two iterations per register stage.
module tdc_cordic (
   input  logic                           clock,
   input  logic                           enable,
   input  logic signed [tdc_pkg::ZW-1:0]  in_z,
   output logic signed [tdc_pkg::XW-1:0]  out_x,
   output logic signed [tdc_pkg::XW-1:0]  out_y
);
   import tdc_pkg::*;

   logic signed [XW-1:0] x_ff [CORDIC_STAGES];
   logic signed [XW-1:0] y_ff [CORDIC_STAGES];
   logic signed [ZW-1:0] z_ff [CORDIC_STAGES];

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
      logic signed [XW-1:0] x_src, y_src, x_in, y_in;
      logic signed [ZW-1:0] z_src, z_in;

      if (g == 0) begin : g_first
         assign x_src = CORDIC_GAIN;
         assign y_src = '0;
         assign z_src = in_z;
      end else begin : g_next
         assign x_src = x_ff[g-1];
         assign y_src = y_ff[g-1];
         assign z_src = z_ff[g-1];
      end

      // rotate toward zero residual angle
      always_comb begin : rot
         logic signed [XW-1:0] dx, dy;
         x_in = x_src;
         y_in = y_src;
         z_in = z_src;
         for (int k = 0; k < CORDIC_PER_STAGE; k++) begin
            dx = y_in >>> (g * CORDIC_PER_STAGE + k);
            dy = x_in >>> (g * CORDIC_PER_STAGE + k);
            if (!z_in[ZW-1]) begin
               x_in = x_in - dx;
               y_in = y_in + dy;
               z_in = z_in - atan_deg(g * CORDIC_PER_STAGE + k);
            end else begin
               x_in = x_in + dx;
               y_in = y_in - dy;
               z_in = z_in + atan_deg(g * CORDIC_PER_STAGE + k);
            end
         end
      end

      // advance stage
      always_ff @(posedge clock) begin
         if (enable) begin
            x_ff[g] <= x_in;
            y_ff[g] <= y_in;
            z_ff[g] <= z_in;
         end
      end
   end

   assign out_x = x_ff[CORDIC_STAGES-1];
   assign out_y = y_ff[CORDIC_STAGES-1];

endmodule

[hw/rtl/transform_2d_compose_top.sv]
// Pipeline: 14 register stages from an accepted request to its result.
// Throughput: one transaction per cycle; the pipeline stalls as a whole only
// while the output register holds a result the sink has not taken.
// Depth: 3 angle-reduction/multiply stages, 8 CORDIC stages, 3 output stages.
// Reset (synchronous, active high) clears every stage valid; data is kept.
module transform_2d_compose_top (
   input  logic      clock,
   input  logic      reset,
   tdc_req_if.sink   req_ch,
   tdc_rsp_if.source rsp_ch
);
   import tdc_pkg::*;

   typedef struct packed {
      logic                 pv;
      logic                 flip;
      logic signed [31:0]   lx;
      logic signed [31:0]   ly;
      logic signed [31:0]   px;
      logic signed [31:0]   py;
      logic signed [AW-1:0] ax;
      logic signed [AW-1:0] ay;
      logic signed [31:0]   g_angle;
      logic signed [31:0]   g_sx;
      logic signed [31:0]   g_sy;
   } side_type;

   typedef struct packed {
      logic                 pv;
      logic signed [31:0]   lx;
      logic signed [31:0]   ly;
      logic signed [31:0]   lsx;
      logic signed [31:0]   lsy;
      logic signed [31:0]   px;
      logic signed [31:0]   py;
      logic [18:0]          low19;
      logic [13:0]          v;
      logic [8:0]           q;
      logic signed [63:0]   p_ax;
      logic signed [63:0]   p_ay;
      logic signed [63:0]   p_sx;
      logic signed [63:0]   p_sy;
      logic signed [31:0]   g_angle;
   } s1_type;

   logic                 adv;
   logic                 rsp_vld_ff;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 s1_vld_ff;
   s1_type               s1_ff, s1_in;
   logic                 s2_vld_ff;
   side_type             s2_ff, s2_in;
   logic [24:0]          s2_r_ff, s2_r_in;
   logic                 s3_vld_ff;
   side_type             s3_ff, s3_in;
   logic signed [ZW-1:0] s3_z_ff, s3_z_in;

   logic                 cp_vld_ff [CORDIC_STAGES];
   side_type             cp_ff [CORDIC_STAGES];
   logic signed [XW-1:0] cx, cy;

   logic                 t_vld_ff;
   side_type             t_ff;
   logic signed [CW-1:0] t_c_ff, t_c_in, t_s_ff, t_s_in;

   logic                 p_vld_ff;
   side_type             p_ff;
   logic signed [TW-1:0] p_axc_ff, p_ays_ff, p_axs_ff, p_ayc_ff;
   logic signed [TW-1:0] p_axc_in, p_ays_in, p_axs_in, p_ayc_in;

   // stall everything only when the output register is full and not taken
   assign adv          = !rsp_vld_ff || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign rsp_ch.valid = rsp_vld_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // stage 1: coarse angle quotient, raw products, angle sum
   always_comb begin : st1
      logic signed [12:0] q1;
      logic [24:0]        qp;
      logic signed [32:0] asum;
      q1          = req_ch.data.parent_angle[31:19];
      s1_in.v     = 14'($signed({q1[12], q1}) + 14'sd4140);
      qp          = 25'(s1_in.v * 11'd1456);
      s1_in.q     = qp[24:16];
      s1_in.low19 = req_ch.data.parent_angle[18:0];
      s1_in.pv    = req_ch.data.parent_valid;
      s1_in.lx    = req_ch.data.local_x;
      s1_in.ly    = req_ch.data.local_y;
      s1_in.lsx   = req_ch.data.local_scale_x;
      s1_in.lsy   = req_ch.data.local_scale_y;
      s1_in.px    = req_ch.data.parent_x;
      s1_in.py    = req_ch.data.parent_y;
      s1_in.p_ax  = req_ch.data.local_x * req_ch.data.parent_scale_x;
      s1_in.p_ay  = req_ch.data.local_y * req_ch.data.parent_scale_y;
      s1_in.p_sx  = req_ch.data.parent_scale_x * req_ch.data.local_scale_x;
      s1_in.p_sy  = req_ch.data.parent_scale_y * req_ch.data.local_scale_y;
      asum        = 33'(req_ch.data.parent_angle) + 33'(req_ch.data.local_angle);
      s1_in.g_angle = req_ch.data.parent_valid ? sat32(66'(asum))
                                               : req_ch.data.local_angle;
   end

   // stage 2: finish angle mod 360, round products
   always_comb begin : st2
      logic [13:0]        rem;
      logic signed [63:0] rax, ray, rsx, rsy;
      logic signed [47:0] vsx, vsy;
      rem     = s1_ff.v - 14'(s1_ff.q * 6'd45);
      if (rem >= 14'd45) begin
         rem = rem - 14'd45;
      end
      s2_r_in = {rem[5:0], s1_ff.low19};
      rax     = s1_ff.p_ax + 64'sd32768;
      ray     = s1_ff.p_ay + 64'sd32768;
      rsx     = s1_ff.p_sx + 64'sd32768;
      rsy     = s1_ff.p_sy + 64'sd32768;
      vsx     = rsx[63:16];
      vsy     = rsy[63:16];
      s2_in.pv      = s1_ff.pv;
      s2_in.flip    = 1'b0;
      s2_in.lx      = s1_ff.lx;
      s2_in.ly      = s1_ff.ly;
      s2_in.px      = s1_ff.px;
      s2_in.py      = s1_ff.py;
      s2_in.ax      = rax[63:16];
      s2_in.ay      = ray[63:16];
      s2_in.g_angle = s1_ff.g_angle;
      s2_in.g_sx    = s1_ff.pv ? sat32(66'(vsx)) : s1_ff.lsx;
      s2_in.g_sy    = s1_ff.pv ? sat32(66'(vsy)) : s1_ff.lsy;
   end

   // stage 3: fold into [-90, 90] with half-turn flip
   always_comb begin : st3
      logic signed [ZW-1:0] r0, r1;
      r0    = $signed({1'b0, s2_r_ff});
      r1    = (r0 > DEG180) ? r0 - DEG360 : r0;
      s3_in = s2_ff;
      if (r1 > DEG90) begin
         s3_z_in    = r1 - DEG180;
         s3_in.flip = 1'b1;
      end else if (r1 < -DEG90) begin
         s3_z_in    = r1 + DEG180;
         s3_in.flip = 1'b1;
      end else begin
         s3_z_in    = r1;
      end
   end

   tdc_cordic u_cordic (
      .clock  (clock),
      .enable (adv),
      .in_z   (s3_z_ff),
      .out_x  (cx),
      .out_y  (cy)
   );

   // trig stage: round to Q16, clamp, apply flip
   always_comb begin : sttrig
      logic signed [XW-1:0] rc, rs;
      logic signed [19:0]   c20, s20;
      logic signed [CW-1:0] cc, sc;
      rc  = cx + 34'sd8192;
      rs  = cy + 34'sd8192;
      c20 = rc[XW-1:14];
      s20 = rs[XW-1:14];
      if (c20 > 20'sd65536) begin
         cc = UNIT_Q16;
      end else if (c20 < -20'sd65536) begin
         cc = -UNIT_Q16;
      end else begin
         cc = c20[CW-1:0];
      end
      if (s20 > 20'sd65536) begin
         sc = UNIT_Q16;
      end else if (s20 < -20'sd65536) begin
         sc = -UNIT_Q16;
      end else begin
         sc = s20[CW-1:0];
      end
      t_c_in = cp_ff[CORDIC_STAGES-1].flip ? -cc : cc;
      t_s_in = cp_ff[CORDIC_STAGES-1].flip ? -sc : sc;
   end

   // product stage: rotate scaled local offset
   always_comb begin : stprod
      logic signed [65:0] m0, m1, m2, m3;
      m0 = t_ff.ax * t_c_ff + 66'sd32768;
      m1 = t_ff.ay * t_s_ff + 66'sd32768;
      m2 = t_ff.ax * t_s_ff + 66'sd32768;
      m3 = t_ff.ay * t_c_ff + 66'sd32768;
      p_axc_in = m0[65:16];
      p_ays_in = m1[65:16];
      p_axs_in = m2[65:16];
      p_ayc_in = m3[65:16];
   end

   // output stage: add parent position, saturate, select pass-through
   always_comb begin : stout
      logic signed [51:0] gx, gy;
      gx = 52'(p_ff.px) + 52'(p_axc_ff) - 52'(p_ays_ff);
      gy = 52'(p_ff.py) + 52'(p_axs_ff) + 52'(p_ayc_ff);
      rsp_data_in.global_x       = p_ff.pv ? sat32(66'(gx)) : p_ff.lx;
      rsp_data_in.global_y       = p_ff.pv ? sat32(66'(gy)) : p_ff.ly;
      rsp_data_in.global_angle   = p_ff.g_angle;
      rsp_data_in.global_scale_x = p_ff.g_sx;
      rsp_data_in.global_scale_y = p_ff.g_sy;
   end

   // hold valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         t_vld_ff   <= 1'b0;
         p_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
         for (int i = 0; i < CORDIC_STAGES; i++) begin
            cp_vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         s1_vld_ff    <= req_ch.valid;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
         cp_vld_ff[0] <= s3_vld_ff;
         for (int i = 1; i < CORDIC_STAGES; i++) begin
            cp_vld_ff[i] <= cp_vld_ff[i-1];
         end
         t_vld_ff   <= cp_vld_ff[CORDIC_STAGES-1];
         p_vld_ff   <= t_vld_ff;
         rsp_vld_ff <= p_vld_ff;
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff    <= s1_in;
         s2_ff    <= s2_in;
         s2_r_ff  <= s2_r_in;
         s3_ff    <= s3_in;
         s3_z_ff  <= s3_z_in;
         cp_ff[0] <= s3_ff;
         for (int i = 1; i < CORDIC_STAGES; i++) begin
            cp_ff[i] <= cp_ff[i-1];
         end
         t_ff        <= cp_ff[CORDIC_STAGES-1];
         t_c_ff      <= t_c_in;
         t_s_ff      <= t_s_in;
         p_ff        <= t_ff;
         p_axc_ff    <= p_axc_in;
         p_ays_ff    <= p_ays_in;
         p_axs_ff    <= p_axs_in;
         p_ayc_ff    <= p_ayc_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !s1_vld_ff && !rsp_vld_ff)
      else $error("valid bits not cleared by reset");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_ch.ready |=> rsp_vld_ff && $stable(rsp_data_ff))
      else $error("stalled result lost or changed");

   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      s3_vld_ff |-> (s3_z_ff <= DEG90) && (s3_z_ff >= -DEG90))
      else $error("folded angle outside +-90 degrees");

   a_trig_range: assert property (@(posedge clock) disable iff (reset)
      t_vld_ff |-> (t_c_ff <= UNIT_Q16) && (t_c_ff >= -UNIT_Q16)
                && (t_s_ff <= UNIT_Q16) && (t_s_ff >= -UNIT_Q16))
      else $error("trig value outside unit range");

endmodule

[bench/tb.sv]
// Testbench for the 2D transform composer, checked against a local predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tdc_pkg::*;

   localparam int LATENCY   = 14;
   localparam int MAX_CYCLES = 400000;

   logic clock;
   logic reset;
   bit   failed;
   bit   no_idle;
   bit   rsp_hold;
   int   cycle_count;

   tdc_req_if req_ch ();
   tdc_rsp_if rsp_ch ();

   rsp_type expected_q[$];

   transform_2d_compose_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // Generate the clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Bound the run
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= MAX_CYCLES) begin
            $display("FAIL transform_2d_compose_top");
            $finish;
         end
      end
   end

   // Floor of v / 2^s (arithmetic shift is a floor)
   function automatic longint floor_sh(longint v, int s);
      return v >>> s;
   endfunction

   // Round half toward plus infinity
   function automatic longint round_sh(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint clip_unit(longint v);
      if (v > 65536) return 65536;
      if (v < -65536) return -65536;
      return v;
   endfunction

   // Cosine and sine of a Q16.16 degree angle, Q16
   task automatic parent_trig(input longint ang, output longint c, output longint s);
      longint tbl[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                          29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
      longint r, x, y, z, dx, dy;
      bit     flip;
      r = ang % 64'sd23592960;
      flip = 1'b0;
      if (r < 0) r += 64'sd23592960;
      if (r > 64'sd11796480) r -= 64'sd23592960;
      if (r > 64'sd5898240) begin
         r -= 64'sd11796480;
         flip = 1'b1;
      end else if (r < -64'sd5898240) begin
         r += 64'sd11796480;
         flip = 1'b1;
      end
      x = 64'sd652032874;
      y = 0;
      z = r;
      for (int i = 0; i < 16; i++) begin
         dx = floor_sh(y, i);
         dy = floor_sh(x, i);
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= tbl[i];
         end else begin
            x += dx;
            y -= dy;
            z += tbl[i];
         end
      end
      c = clip_unit(round_sh(x, 14));
      s = clip_unit(round_sh(y, 14));
      if (flip) begin
         c = -c;
         s = -s;
      end
   endtask

   // Compose one child transform with its parent
   task automatic compose_transform(input req_type t, output rsp_type r);
      longint c, s, ax, ay;
      if (!t.parent_valid) begin
         r.global_x       = t.local_x;
         r.global_y       = t.local_y;
         r.global_angle   = t.local_angle;
         r.global_scale_x = t.local_scale_x;
         r.global_scale_y = t.local_scale_y;
         return;
      end
      parent_trig(longint'(t.parent_angle), c, s);
      ax = round_sh(longint'(t.local_x) * longint'(t.parent_scale_x), 16);
      ay = round_sh(longint'(t.local_y) * longint'(t.parent_scale_y), 16);
      r.global_x = 32'(clip32(longint'(t.parent_x) + round_sh(ax * c, 16)
                              - round_sh(ay * s, 16)));
      r.global_y = 32'(clip32(longint'(t.parent_y) + round_sh(ax * s, 16)
                              + round_sh(ay * c, 16)));
      r.global_angle = 32'(clip32(longint'(t.parent_angle) + longint'(t.local_angle)));
      r.global_scale_x = 32'(clip32(round_sh(longint'(t.parent_scale_x)
                                             * longint'(t.local_scale_x), 16)));
      r.global_scale_y = 32'(clip32(round_sh(longint'(t.parent_scale_y)
                                             * longint'(t.local_scale_y), 16)));
   endtask

   // Send one transaction, with random idle cycles; valid stays up for the next one
   task automatic send_transform(input req_type t);
      rsp_type r;
      while (!no_idle && $urandom_range(99) < 15) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= t;
      do @(posedge clock); while (!req_ch.ready);
      compose_transform(t, r);
      expected_q.insert(expected_q.size(), r);
   endtask

   // Drive the result ready with random stalls or a hold-off
   always @(posedge clock) begin
      if (reset || rsp_hold) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= no_idle || ($urandom_range(99) >= 15);
      end
   end

   // Check each result against the oldest expectation
   always @(posedge clock) begin
      rsp_type e, a;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         a = rsp_ch.data;
         if (expected_q.size() == 0) begin
            $error("result with no expectation waiting: %h", a);
            failed = 1'b1;
         end else begin
            e = expected_q.pop_front();
            if (a.global_x !== e.global_x) begin
               $error("global_x exp %0d got %0d", e.global_x, a.global_x);
               failed = 1'b1;
            end
            if (a.global_y !== e.global_y) begin
               $error("global_y exp %0d got %0d", e.global_y, a.global_y);
               failed = 1'b1;
            end
            if (a.global_angle !== e.global_angle) begin
               $error("global_angle exp %0d got %0d", e.global_angle, a.global_angle);
               failed = 1'b1;
            end
            if (a.global_scale_x !== e.global_scale_x) begin
               $error("global_scale_x exp %0d got %0d", e.global_scale_x, a.global_scale_x);
               failed = 1'b1;
            end
            if (a.global_scale_y !== e.global_scale_y) begin
               $error("global_scale_y exp %0d got %0d", e.global_scale_y, a.global_scale_y);
               failed = 1'b1;
            end
         end
      end
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(5))
         0:       return 32'h7fffffff;
         1:       return 32'h80000000;
         2:       return $urandom_range(65536 * 4);
         3:       return -$urandom_range(65536 * 4);
         default: return $urandom;
      endcase
   endfunction

   // Random transform mixing extremes, small magnitudes and full-range words
   function automatic req_type rand_transform();
      req_type t;
      t.local_x        = rand_word();
      t.local_y        = rand_word();
      t.local_angle    = rand_word();
      t.local_scale_x  = rand_word();
      t.local_scale_y  = rand_word();
      t.parent_x       = rand_word();
      t.parent_y       = rand_word();
      t.parent_angle   = $urandom_range(3) == 0 ? $urandom
                         : 32'($signed($urandom_range(1440)) - 720) <<< 16;
      t.parent_scale_x = rand_word();
      t.parent_scale_y = rand_word();
      t.parent_valid   = $urandom_range(4) != 0;
      return t;
   endfunction

   // Drop valid and wait for every outstanding result
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   // Extremes, pass-through and special angles
   task automatic test_directed();
      req_type t;
      int angs[12] = '{0, 90, -90, 180, -180, 270, 360, 45, 135, -135, 720, -450};
      t = '0;
      t.local_x = 32'sh7fffffff;  t.local_y = 32'sh80000000;
      t.local_angle = 32'sh7fffffff; t.local_scale_x = 32'sh80000000;
      t.local_scale_y = 32'sh7fffffff; t.parent_x = 32'sh12345678;
      send_transform(t);
      t.parent_valid = 1'b1; t.parent_angle = 32'sh7fffffff;
      t.parent_scale_x = 32'sh7fffffff; t.parent_scale_y = 32'sh80000000;
      t.parent_x = 32'sh7fffffff; t.parent_y = 32'sh80000000;
      send_transform(t);
      t.parent_angle = 32'sh80000000; t.local_angle = 32'sh80000000;
      send_transform(t);
      for (int i = 0; i < 12; i++) begin
         t = '0;
         t.parent_valid = 1'b1;
         t.local_x = 32'sd2560; t.local_y = -32'sd512;
         t.local_scale_x = 32'sd65536; t.local_scale_y = 32'sd131072;
         t.parent_scale_x = 32'sd65536; t.parent_scale_y = 32'sd98304;
         t.parent_angle = angs[i] <<< 16; t.local_angle = 32'sd32768;
         t.parent_x = 32'sd1000;
         send_transform(t);
      end
      t.parent_angle = 32'sd1; send_transform(t);
      t.parent_angle = -32'sd1; send_transform(t);
      t = '1; send_transform(t);
      t = '0; send_transform(t);
   endtask

   // Random traffic with a stretch of no idling
   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         no_idle = (i >= count / 3) && (i < count / 2);
         send_transform(rand_transform());
      end
      no_idle = 1'b0;
   endtask

   // Hold off the receiver so the pipeline fills and backpressures
   task automatic test_backpressure();
      rsp_hold = 1'b1;
      fork
         begin
            repeat (60) @(posedge clock);
            rsp_hold = 1'b0;
         end
         for (int i = 0; i < 40; i++) send_transform(rand_transform());
      join
      wait_drained();
   endtask

   initial begin
      req_type idle_item;
      failed   = 1'b0;
      no_idle  = 1'b0;
      rsp_hold = 1'b0;
      idle_item = '0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data  = idle_item;
      rsp_ch.ready = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      wait_drained();
      test_backpressure();
      test_random(1550);
      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      if (!failed && expected_q.size() == 0) begin
         $display("PASS transform_2d_compose_top");
      end else begin
         $display("FAIL transform_2d_compose_top");
      end
      $finish;
   end
endmodule
